### rtl/mbq_pkg.sv
// Shared types, widths, stage map and constants of the multichannel bin quantizer.
package mbq_pkg;

    // Channel and field widths
    localparam int MAX_CHANNELS = 4;
    localparam int SAMPLE_W     = 23;
    localparam int WORK_W       = 32;
    localparam int BINS_W       = 9;
    localparam int CHAN_W       = 3;
    localparam int NC_W         = CHAN_W + 1;
    localparam int IDX_W        = BINS_W;
    localparam int LABEL_W      = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;

    // Log unit widths
    localparam int A_W          = WORK_W - 1;
    localparam int M_W          = A_W;
    localparam int SQ_W         = 2 * M_W;
    localparam int P_W          = $clog2(A_W);
    localparam int PM_W         = P_W + 1;
    localparam int FRAC_W       = 16;
    localparam int SQ_STEPS     = FRAC_W;
    localparam int L2_W         = PM_W + FRAC_W;
    localparam int LN2_W        = 33;
    localparam int LNP_W        = L2_W + LN2_W;
    localparam int LN_SHIFT     = 36;
    localparam int LOG_INT_OFFSET = 12;

    // Binning multiply widths
    localparam int INV_HALF_W   = 16;
    localparam int PROD_W       = WORK_W + INV_HALF_W;
    localparam int PSUM_W       = PROD_W + 1;
    localparam int BIN_SHIFT    = 12;
    localparam int Q_W          = PSUM_W - BIN_SHIFT;

    // Fixed-point constants
    localparam logic signed [WORK_W-1:0] ONE_Q12      = 32'sd4096;
    localparam logic signed [WORK_W-1:0] XFORM_OFFSET = 32'sd1044480;
    localparam int                       XFORM_SHIFT  = 8;
    localparam logic signed [LN2_W-1:0]  LN2_Q32      = 33'sd2977044472;

    // Pipeline stage map: lane stages, then one merge stage per channel
    localparam int ST_XFORM     = 0;
    localparam int ST_LOD       = 1;
    localparam int ST_NORM      = 2;
    localparam int ST_SQ0       = 3;
    localparam int ST_LNMUL     = ST_SQ0 + SQ_STEPS;
    localparam int ST_SUB       = ST_LNMUL + 1;
    localparam int ST_BMUL      = ST_SUB + 1;
    localparam int ST_CLAMP     = ST_BMUL + 1;
    localparam int LANE_STAGES  = ST_CLAMP + 1;
    localparam int ST_MERGE0    = LANE_STAGES;
    localparam int NUM_STAGES   = LANE_STAGES + MAX_CHANNELS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_SPACE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BOUND        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DELTA        = 3'd5;

    // Reset values
    localparam logic [BINS_W-1:0]     BIN_COUNT_RST     = 9'd16;
    localparam logic [CHAN_W-1:0]     CHANNEL_COUNT_RST = 3'd1;
    localparam logic [CFG_DATA_W-1:0] INV_DELTA_RST     = 32'd65536;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WORK_W-1:0]   t_work;
    typedef logic [IDX_W-1:0]           t_idx;

    typedef struct packed {
        logic                    transform_enable;
        logic                    log_space;
        logic [BINS_W-1:0]       bin_count;
        logic [CHAN_W-1:0]       channel_count;
        logic [CFG_DATA_W-1:0]   min_bound;
        logic [CFG_DATA_W-1:0]   inv_delta;
    } t_cfg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

endpackage

### rtl/mbq_if.sv
// Pixel request and label request channel interfaces.
interface mbq_pix_if;
    import mbq_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_0;
    t_sample sample_1;
    t_sample sample_2;
    t_sample sample_3;

    modport source (output valid, output sample_0, output sample_1,
                    output sample_2, output sample_3, input ready);
    modport sink   (input valid, input sample_0, input sample_1,
                    input sample_2, input sample_3, output ready);
endinterface

interface mbq_label_if;
    import mbq_pkg::*;

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] label;

    modport source (output valid, output label, input ready);
    modport sink   (input valid, input label, output ready);
endinterface

### rtl/mbq_regs.sv
// Configuration register file of the bin quantizer.
module mbq_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mbq_pkg::t_cfg                    o_cfg
);
    import mbq_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transform_enable <= 1'b0;
            r_cfg.log_space        <= 1'b0;
            r_cfg.bin_count        <= BIN_COUNT_RST;
            r_cfg.channel_count    <= CHANNEL_COUNT_RST;
            r_cfg.min_bound        <= '0;
            r_cfg.inv_delta        <= INV_DELTA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRANSFORM_ENABLE: r_cfg.transform_enable <= i_cfg_data[0];
                REG_LOG_SPACE:        r_cfg.log_space        <= i_cfg_data[0];
                REG_BIN_COUNT:        r_cfg.bin_count        <= i_cfg_data[BINS_W-1:0];
                REG_CHANNEL_COUNT:    r_cfg.channel_count    <= i_cfg_data[CHAN_W-1:0];
                REG_MIN_BOUND:        r_cfg.min_bound        <= i_cfg_data;
                REG_INV_DELTA:        r_cfg.inv_delta        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/mbq_lane.sv
// One channel lane: range transform, pipelined natural log, and bin index.
module mbq_lane (
    input  logic               i_clk,
    input  mbq_pkg::t_cfg      i_cfg,
    input  mbq_pkg::t_pipe_ctl i_ctl,
    input  mbq_pkg::t_sample   i_sample,
    output mbq_pkg::t_idx      o_idx
);
    import mbq_pkg::*;

    // Range transform: v*127.5 + 127.5 as floor((x*255 + 255*4096) / 2)
    t_work w_x_ext;
    t_work n_xf_sum;
    t_work n_v0;
    t_work r_v0;

    always_comb begin
        w_x_ext  = {{(WORK_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
        n_xf_sum = (w_x_ext <<< XFORM_SHIFT) - w_x_ext + XFORM_OFFSET;
        n_v0     = i_cfg.transform_enable ? (n_xf_sum >>> 1) : w_x_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_XFORM]) begin
            r_v0 <= n_v0;
        end
    end

    // Log argument v+1 and its leading one position
    t_work            n_a;
    logic             n_lz;
    logic [P_W-1:0]   n_p;
    logic [A_W-1:0]   r_a;
    logic [P_W-1:0]   r_p;
    logic             r_lz;
    t_work            r_v1;

    always_comb begin
        n_a  = r_v0 + ONE_Q12;
        n_lz = n_a[WORK_W-1] || (n_a == '0);
        n_p  = '0;
        for (int i = 0; i < A_W; i++) begin
            if (n_a[i]) begin
                n_p = P_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_LOD]) begin
            r_a  <= n_a[A_W-1:0];
            r_p  <= n_p;
            r_lz <= n_lz;
            r_v1 <= r_v0;
        end
    end

    // Normalize the argument to a Q30 mantissa in [1,2)
    logic [M_W-1:0]   r_m    [0:SQ_STEPS-1];
    logic [FRAC_W-1:0] r_frac [0:SQ_STEPS-1];
    logic [P_W-1:0]   r_p_d  [0:SQ_STEPS];
    logic             r_lz_d [0:SQ_STEPS];
    t_work            r_v_d  [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_NORM]) begin
            r_m[0]    <= r_a << (P_W'(A_W-1) - r_p);
            r_p_d[0]  <= r_p;
            r_lz_d[0] <= r_lz;
            r_v_d[0]  <= r_v1;
        end
    end

    // One log2 fraction bit per stage by squaring the mantissa
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
        logic [SQ_W-1:0]   w_sq;
        logic              w_bit;
        logic [FRAC_W-1:0] w_frac_prev;

        always_comb begin
            w_sq  = r_m[i] * r_m[i];
            w_bit = w_sq[SQ_W-1];
        end

        if (i == 0) begin : g_first
            assign w_frac_prev = '0;
        end else begin : g_next
            assign w_frac_prev = r_frac[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[ST_SQ0+i]) begin
                r_frac[i]   <= {w_frac_prev[FRAC_W-2:0], w_bit};
                r_p_d[i+1]  <= r_p_d[i];
                r_lz_d[i+1] <= r_lz_d[i];
                r_v_d[i+1]  <= r_v_d[i];
            end
        end

        if (i < SQ_STEPS - 1) begin : g_mant
            always_ff @(posedge i_clk) begin
                if (i_ctl.load[ST_SQ0+i]) begin
                    r_m[i+1] <= w_bit ? w_sq[SQ_W-1:SQ_W-M_W] : w_sq[SQ_W-2:SQ_W-M_W-1];
                end
            end
        end
    end

    // Scale log2 (Q16) by ln 2
    logic [PM_W-1:0]          n_pm;
    logic signed [L2_W-1:0]   n_l2;
    logic signed [LNP_W-1:0]  n_lnp;
    logic signed [LNP_W-1:0]  r_lnp;
    logic                     r_lz3;
    t_work                    r_v3;

    always_comb begin
        n_pm  = {1'b0, r_p_d[SQ_STEPS]} - PM_W'(LOG_INT_OFFSET);
        n_l2  = $signed({n_pm, r_frac[SQ_STEPS-1]});
        n_lnp = n_l2 * LN2_Q32;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_LNMUL]) begin
            r_lnp <= n_lnp;
            r_lz3 <= r_lz_d[SQ_STEPS];
            r_v3  <= r_v_d[SQ_STEPS];
        end
    end

    // Truncate ln toward zero, pick the working value, subtract the lower edge
    localparam logic signed [LNP_W-1:0] LN_BIAS = LNP_W'((64'sd1 <<< LN_SHIFT) - 64'sd1);

    logic signed [LNP_W-1:0]  n_ln_rnd;
    t_work                    n_ln;
    t_work                    n_w;
    logic signed [WORK_W:0]   n_d;
    logic                     n_zb;
    logic [WORK_W-1:0]        r_ud;
    logic                     r_zb;

    always_comb begin
        n_ln_rnd = r_lnp + (r_lnp[LNP_W-1] ? LN_BIAS : '0);
        n_ln     = WORK_W'(n_ln_rnd >>> LN_SHIFT);
        n_w      = i_cfg.log_space ? n_ln : r_v3;
        n_d      = {n_w[WORK_W-1], n_w}
                 - {i_cfg.min_bound[WORK_W-1], i_cfg.min_bound};
        n_zb     = (i_cfg.log_space && r_lz3) || n_d[WORK_W] || (n_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_SUB]) begin
            r_ud <= n_d[WORK_W-1:0];
            r_zb <= n_zb;
        end
    end

    // Multiply by the inverse bin width as two half-width products
    logic [PROD_W-1:0] r_pa;
    logic [PROD_W-1:0] r_pb;
    logic              r_zb2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_BMUL]) begin
            r_pa  <= r_ud * i_cfg.inv_delta[CFG_DATA_W-1:INV_HALF_W];
            r_pb  <= r_ud * i_cfg.inv_delta[INV_HALF_W-1:0];
            r_zb2 <= r_zb;
        end
    end

    // Combine the products, take the integer part and clamp to the bin range
    logic [PSUM_W-1:0] n_sum;
    logic [Q_W-1:0]    n_q;
    logic [BINS_W-1:0] n_nb;
    t_idx              n_idx;
    t_idx              r_idx;

    always_comb begin
        n_sum = PSUM_W'(r_pa) + PSUM_W'(r_pb[PROD_W-1:INV_HALF_W]);
        n_q   = n_sum[PSUM_W-1:BIN_SHIFT];
        n_nb  = (i_cfg.bin_count == '0) ? BINS_W'(1) : i_cfg.bin_count;
        if (r_zb2) begin
            n_idx = '0;
        end else if (n_q >= Q_W'(n_nb)) begin
            n_idx = n_nb - BINS_W'(1);
        end else begin
            n_idx = n_q[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_CLAMP]) begin
            r_idx <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

### rtl/mbq_merge.sv
// Mixed-radix merge of the lane bin indices, one channel per stage.
module mbq_merge (
    input  logic                          i_clk,
    input  mbq_pkg::t_cfg                 i_cfg,
    input  mbq_pkg::t_pipe_ctl            i_ctl,
    input  mbq_pkg::t_idx                 i_idx [mbq_pkg::MAX_CHANNELS],
    output logic [mbq_pkg::LABEL_W-1:0]   o_label
);
    import mbq_pkg::*;

    logic [NC_W-1:0]    w_nc;
    logic [LABEL_W-1:0] r_acc  [MAX_CHANNELS];
    t_idx               r_pend [MAX_CHANNELS][MAX_CHANNELS];

    // Saturate the channel count to the lane count
    always_comb begin
        if ({1'b0, i_cfg.channel_count} > NC_W'(MAX_CHANNELS)) begin
            w_nc = NC_W'(MAX_CHANNELS);
        end else begin
            w_nc = {1'b0, i_cfg.channel_count};
        end
    end

    // Fold in one channel per stage, channel 0 most significant
    for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_stage
        logic [LABEL_W-1:0]        w_prev;
        t_idx                      w_in [MAX_CHANNELS];
        logic [LABEL_W+BINS_W-1:0] w_prod;
        logic [LABEL_W-1:0]        n_acc;

        if (j == 0) begin : g_first
            assign w_prev = '0;
            assign w_in   = i_idx;
        end else begin : g_next
            assign w_prev = r_acc[j-1];
            assign w_in   = r_pend[j-1];
        end

        always_comb begin
            w_prod = w_prev * i_cfg.bin_count;
            if (NC_W'(j) < w_nc) begin
                n_acc = w_prod[LABEL_W-1:0] + LABEL_W'(w_in[j]);
            end else begin
                n_acc = w_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[ST_MERGE0+j]) begin
                r_acc[j]  <= n_acc;
                r_pend[j] <= w_in;
            end
        end
    end

    assign o_label = r_acc[MAX_CHANNELS-1];

endmodule

### rtl/multichannel_bin_quantizer_core.sv
// Top level: pixel intake, lane array, label merge and output buffer.
//
// Turns one pixel of up to four signed Q10.12 channel samples into one
// mixed-radix class label. The block takes one pixel per clock cycle while
// i_pix.ready is high: each channel has its own lane (range transform, a
// natural log built from 16 squaring stages, and a 32 x 32 bin multiply done
// as two 32 x 16 halves), and four merge stages fold the lane indices into
// the label, channel 0 most significant. The output side has a two-entry
// buffer: a pixel request is still accepted while one label waits, and
// i_pix.ready drops only while two labels wait. The pipeline has no clearing
// pass after reset; the user must write configuration registers through the
// plain write port while no pixel is in flight (the block does not check).
module multichannel_bin_quantizer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mbq_pix_if.sink                          i_pix,
    mbq_label_if.source                      o_lbl,
    input  logic                             i_cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mbq_pkg::*;

    t_cfg               w_cfg;
    t_pipe_ctl          w_ctl;
    logic               w_en;
    t_sample            w_samples [MAX_CHANNELS];
    t_idx               w_idx     [MAX_CHANNELS];
    logic [LABEL_W-1:0] w_label;
    logic [NUM_STAGES-1:0] r_valid;

    logic               r_ov;
    logic               r_sv;
    logic [LABEL_W-1:0] r_out_label;
    logic [LABEL_W-1:0] r_spare_label;
    logic               n_ov;
    logic               n_sv;
    logic               w_push;
    logic               w_pop;
    logic               w_load_out;
    logic               w_from_spare;
    logic               w_load_spare;

    mbq_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Advance the pipeline whenever the spare output slot is free
    assign w_en        = !r_sv;
    assign i_pix.ready = w_en;

    always_comb begin
        w_ctl.load[0] = w_en && i_pix.valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            w_ctl.load[k] = w_en && r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NUM_STAGES-2:0], i_pix.valid};
        end
    end

    assign w_samples[0] = i_pix.sample_0;
    assign w_samples[1] = i_pix.sample_1;
    assign w_samples[2] = i_pix.sample_2;
    assign w_samples[3] = i_pix.sample_3;

    for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
        mbq_lane u_lane (
            .i_clk    (i_clk),
            .i_cfg    (w_cfg),
            .i_ctl    (w_ctl),
            .i_sample (w_samples[k]),
            .o_idx    (w_idx[k])
        );
    end

    mbq_merge u_merge (
        .i_clk   (i_clk),
        .i_cfg   (w_cfg),
        .i_ctl   (w_ctl),
        .i_idx   (w_idx),
        .o_label (w_label)
    );

    // Two-entry output buffer: hold a waiting label, park the next one
    assign w_push = r_valid[NUM_STAGES-1] && w_en;
    assign w_pop  = r_ov && o_lbl.ready;

    always_comb begin
        n_ov         = r_ov;
        n_sv         = r_sv;
        w_load_out   = 1'b0;
        w_from_spare = 1'b0;
        w_load_spare = 1'b0;
        if (w_pop) begin
            if (r_sv) begin
                w_load_out   = 1'b1;
                w_from_spare = 1'b1;
                n_sv         = 1'b0;
            end else if (w_push) begin
                w_load_out = 1'b1;
            end else begin
                n_ov = 1'b0;
            end
        end else if (w_push) begin
            if (r_ov) begin
                w_load_spare = 1'b1;
                n_sv         = 1'b1;
            end else begin
                w_load_out = 1'b1;
                n_ov       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_label <= w_from_spare ? r_spare_label : w_label;
        end
        if (w_load_spare) begin
            r_spare_label <= w_label;
        end
    end

    assign o_lbl.valid = r_ov;
    assign o_lbl.label = r_out_label;

endmodule
